[hw/rtl/csra_pkg.sv]
`default_nettype none
package csra_pkg;

    localparam int BUF_BYTES = 64;
    localparam int LANES     = 8;
    localparam int ROWS      = BUF_BYTES / LANES;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int POS_W     = $clog2(BUF_BYTES) + 1;

    localparam logic [1:0] SEG_SINGLE = 2'd0;
    localparam logic [1:0] SEG_FIRST  = 2'd1;
    localparam logic [1:0] SEG_MIDDLE = 2'd2;
    localparam logic [1:0] SEG_FINAL  = 2'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_BOOT = 1'b1;

    localparam logic CFG_LOCAL_STATION = 1'b0;
    localparam logic CFG_BOOT_FUNC     = 1'b1;

    typedef logic [LANES-1:0][7:0] lane_data_t;

    typedef struct packed {
        logic             kind;
        logic [3:0]       cnt;
        logic [POS_W-1:0] len;
        logic [3:0]       func;
        logic [7:0]       src;
        logic             last;
    } word_meta_t;

endpackage
`default_nettype wire

[hw/rtl/csra_lane.sv]
`default_nettype none
module csra_lane (
    input  wire logic                       aclk,
    input  wire logic [2:0]                 lane_id,
    input  wire logic                       wr_go,
    input  wire logic [csra_pkg::POS_W-1:0] wr_base,
    input  wire logic [3:0]                 wr_dlc,
    input  wire logic [63:0]                wr_payload,
    input  wire logic                       rd_en,
    input  wire logic [csra_pkg::ROW_W-1:0] rd_row,
    output logic [7:0]                      rd_byte
);
    import csra_pkg::*;

    logic [7:0]       mem [ROWS];
    logic [2:0]       src_idx;
    logic [POS_W-1:0] pos;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic [7:0]       wr_byte;

    // payload byte that lands in this lane for the given start offset
    assign src_idx = lane_id - wr_base[2:0];
    assign pos     = wr_base + POS_W'(src_idx);
    assign wr_en   = wr_go && ({1'b0, src_idx} < wr_dlc);
    assign wr_row  = pos[ROW_W+2:3];
    assign wr_byte = wr_payload[8*src_idx +: 8];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_byte <= mem[rd_row];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/csra_merge.sv]
`default_nettype none
module csra_merge (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    input  wire csra_pkg::word_meta_t    in_meta,
    input  wire csra_pkg::lane_data_t    in_lanes,
    output logic                         in_ready,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // word_data[63:0], word_bytes[67:64], message_length[74:68],
    // function_code[78:75], source_station[86:79], zero pad [87]
    output logic [87:0]                  m_tdata,
    output logic                         m_tlast,
    // kind
    output logic                         m_tuser
);
    import csra_pkg::*;

    logic        valid_reg;
    logic [87:0] data_reg;
    logic        last_reg;
    logic        kind_reg;
    logic [63:0] word;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            word[8*l +: 8] = (4'(l) < in_meta.cnt) ? in_lanes[l] : 8'h00;
        end
    end

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= {1'b0, in_meta.src, in_meta.func, in_meta.len, in_meta.cnt, word};
            last_reg <= in_meta.last;
            kind_reg <= in_meta.kind;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = kind_reg;

endmodule
`default_nettype wire

[hw/rtl/can_segment_reassembler.sv]
`default_nettype none
// Rebuilds segmented messages from extended-ID CAN frames. A frame that
// completes nothing starts no readout, so such frames go back to back while
// no readout runs. A frame that completes a message (or a boot request to this
// station) starts a readout of max(1, ceil(len/8)) words, one word per cycle
// while the output accepts, from eight byte-lane stores of 8 rows each; the
// next frame is taken in the cycle the last word's row is read. The first word
// passes the sequencer, lane read registers and merge register to m_tvalid.
// Registers: index 0 local station (7 bits), index 1 boot function (4 bits).
module can_segment_reassembler (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [6:0]   cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // ext_id[28:0], dlc[32:29], payload[96:33], zero pad [103:97]
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // word_data[63:0], word_bytes[67:64], message_length[74:68],
    // function_code[78:75], source_station[86:79], zero pad [87]
    output logic [87:0]       m_tdata,
    output logic              m_tlast,
    // kind
    output logic              m_tuser
);
    import csra_pkg::*;

    logic [6:0]       loc_station_reg;
    logic [3:0]       boot_func_reg;
    logic             session_reg, session_next;
    logic [7:0]       exp_seq_reg, exp_seq_next;
    logic [POS_W-1:0] gathered_reg, gathered_next;

    logic [28:0]      id;
    logic [3:0]       dlc_raw, dlc_sat;
    logic [63:0]      payload;
    logic [1:0]       seg;
    logic [7:0]       seq;
    logic [3:0]       func;
    logic [7:0]       src;
    logic [6:0]       dst;

    logic             accept, is_boot, seq_ok, fits, cont_ok;
    logic [POS_W:0]   fill_sum;
    logic             wr_go, done, res_go;
    logic [POS_W-1:0] wr_base, done_len, res_len, len_m1;

    logic             rd_active_reg, rd_active_next;
    logic [ROW_W-1:0] rd_word_reg, rd_word_next;
    logic [ROW_W-1:0] rd_last_reg, rd_last_next;
    logic             rd_kind_reg;
    logic [POS_W-1:0] rd_len_reg;
    logic [3:0]       rd_func_reg;
    logic [7:0]       rd_src_reg;

    logic             issue, issue_last, b_ready;
    logic             b_valid_reg;
    word_meta_t       b_meta_reg, issue_meta;
    logic [POS_W-1:0] word_base, word_rem;
    lane_data_t       lane_q;

    // frame decode
    assign id      = s_tdata[28:0];
    assign dlc_raw = s_tdata[32:29];
    assign payload = s_tdata[96:33];
    assign seg     = id[21:20];
    assign seq     = id[19:12];
    assign func    = id[11:8];
    assign src     = id[7:0];
    assign dst     = id[28:22];
    assign dlc_sat = (dlc_raw > 4'd8) ? 4'd8 : dlc_raw;

    assign accept   = s_tvalid && s_tready;
    assign is_boot  = (func == boot_func_reg) && (dst == loc_station_reg);
    assign seq_ok   = ({1'b0, seq} == ({1'b0, exp_seq_reg} + 9'd1));
    assign fill_sum = {1'b0, gathered_reg} + (POS_W+1)'(dlc_sat);
    assign fits     = fill_sum <= (POS_W+1)'(BUF_BYTES);
    assign cont_ok  = session_reg && seq_ok && fits;

    always_comb begin
        wr_go         = 1'b0;
        wr_base       = '0;
        done          = 1'b0;
        done_len      = '0;
        session_next  = session_reg;
        exp_seq_next  = exp_seq_reg;
        gathered_next = gathered_reg;
        case (seg)
            SEG_SINGLE: begin
                wr_go    = 1'b1;
                done     = 1'b1;
                done_len = POS_W'(dlc_sat);
            end
            SEG_FIRST: begin
                wr_go         = 1'b1;
                session_next  = 1'b1;
                exp_seq_next  = seq;
                gathered_next = POS_W'(dlc_sat);
            end
            default: begin
                wr_go   = cont_ok;
                wr_base = gathered_reg;
                if (cont_ok) begin
                    if (seg == SEG_MIDDLE) begin
                        exp_seq_next  = seq;
                        gathered_next = fill_sum[POS_W-1:0];
                    end else begin
                        done          = 1'b1;
                        done_len      = fill_sum[POS_W-1:0];
                        session_next  = 1'b0;
                        exp_seq_next  = '0;
                        gathered_next = '0;
                    end
                end
            end
        endcase
    end

    assign res_go  = accept && (is_boot || done);
    assign res_len = is_boot ? '0 : done_len;
    assign len_m1  = res_len - POS_W'(1);
    // index of the final word; an empty message still gives one word
    assign rd_last_next = (res_len == '0) ? '0 : len_m1[ROW_W+2:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loc_station_reg <= '0;
            boot_func_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LOCAL_STATION: loc_station_reg <= cfg_data;
                CFG_BOOT_FUNC:     boot_func_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg  <= 1'b0;
            exp_seq_reg  <= '0;
            gathered_reg <= '0;
        end else if (accept && !is_boot) begin
            session_reg  <= session_next;
            exp_seq_reg  <= exp_seq_next;
            gathered_reg <= gathered_next;
        end
    end

    // readout sequencer
    assign issue      = rd_active_reg && (!b_valid_reg || b_ready);
    assign issue_last = issue && (rd_word_reg == rd_last_reg);
    assign s_tready   = !rd_active_reg || issue_last;

    always_comb begin
        rd_active_next = rd_active_reg;
        rd_word_next   = rd_word_reg;
        if (res_go) begin
            rd_active_next = 1'b1;
            rd_word_next   = '0;
        end else if (issue_last) begin
            rd_active_next = 1'b0;
        end else if (issue) begin
            rd_word_next = rd_word_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_active_reg <= 1'b0;
            rd_word_reg   <= '0;
        end else begin
            rd_active_reg <= rd_active_next;
            rd_word_reg   <= rd_word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_go) begin
            rd_last_reg <= rd_last_next;
            rd_kind_reg <= is_boot ? KIND_BOOT : KIND_DATA;
            rd_len_reg  <= res_len;
            rd_func_reg <= func;
            rd_src_reg  <= src;
        end
    end

    assign word_base = POS_W'({rd_word_reg, 3'b000});
    assign word_rem  = rd_len_reg - word_base;

    always_comb begin
        issue_meta.kind = rd_kind_reg;
        issue_meta.len  = rd_len_reg;
        issue_meta.func = rd_func_reg;
        issue_meta.src  = rd_src_reg;
        issue_meta.last = (rd_word_reg == rd_last_reg);
        if (rd_len_reg <= word_base) begin
            issue_meta.cnt = 4'd0;
        end else if (word_rem >= POS_W'(8)) begin
            issue_meta.cnt = 4'd8;
        end else begin
            issue_meta.cnt = word_rem[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (issue) begin
            b_valid_reg <= 1'b1;
        end else if (b_ready) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            b_meta_reg <= issue_meta;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        csra_lane u_lane (
            .aclk       (aclk),
            .lane_id    (3'(l)),
            .wr_go      (accept && !is_boot && wr_go),
            .wr_base    (wr_base),
            .wr_dlc     (dlc_sat),
            .wr_payload (payload),
            .rd_en      (issue),
            .rd_row     (rd_word_reg),
            .rd_byte    (lane_q[l])
        );
    end

    csra_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (b_valid_reg),
        .in_meta  (b_meta_reg),
        .in_lanes (lane_q),
        .in_ready (b_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        gathered_reg <= POS_W'(BUF_BYTES))
        else $error("byte count past buffer size");

    a_closed_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !session_reg |-> (gathered_reg == '0) && (exp_seq_reg == '0))
        else $error("closed session holds state");

    a_boot_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_BOOT) |-> m_tlast && (m_tdata[74:0] == '0))
        else $error("boot result carries data");

    a_no_write_in_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && rd_active_reg |-> issue_last)
        else $error("frame taken while words still unread");
`endif

endmodule
`default_nettype wire
